### rtl/lctd_pkg.sv
// shared types and constants for the load cell tap detector
// no dependencies; imported by the core top level and the bench
`default_nettype none

package lctd_pkg;

  localparam int SAMPLE_W = 24;

  // rail detection threshold on the sample magnitude
  localparam logic [SAMPLE_W-1:0] RAIL_LIMIT = 24'h7FC000;
  localparam logic [3:0]          RAIL_SAT   = 4'd15;

  // ema gains as shifts: slow 1/128, fast 1/32
  localparam int SLOW_SHIFT = 7;
  localparam int FAST_SHIFT = 5;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_ENABLE  = 2'd1,
    KIND_DISABLE = 2'd2,
    KIND_ARM     = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                      kind;
    logic signed [SAMPLE_W-1:0] raw_sample;
  } item_t;

  typedef struct packed {
    logic                       trigger_out;
    logic signed [SAMPLE_W-1:0] moving_average;
    logic [SAMPLE_W-1:0]        diff_magnitude;
    logic                       fault;
  } result_t;

endpackage

`default_nettype wire

### rtl/lctd_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module lctd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 50
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/load_cell_tap_detector_core.sv
// load cell tap detector: rail fault, moving average window, dual ema trigger
// path: an accepted request is registered in p1, p2 and p3, then in the result register
// throughput: one request per cycle unless the output stalls; the window ram is read at
// the next pointer, so its read-modify-write never stalls
// reset: synchronous, clears all state but the pipeline data; the window ram is not swept, entries
// read as zero until the pointer has wrapped once
`default_nettype none

module load_cell_tap_detector_core #(
  parameter int WINDOW_LENGTH = 50,
  parameter int RAIL_DEBOUNCE = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire lctd_pkg::item_t       item,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output lctd_pkg::result_t          result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic signed [23:0]    cfg_data
);

  import lctd_pkg::*;

  localparam int PTR_W = $clog2(WINDOW_LENGTH);
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LENGTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(WINDOW_LENGTH - 1);
  localparam logic [SUM_W-1:0] LEN_W    = SUM_W'(WINDOW_LENGTH);
  localparam logic [SUM_W-1:0] RECIP    = SUM_W'((64'd1 << SUM_W) / WINDOW_LENGTH);
  localparam logic [3:0]       DEBOUNCE = 4'(RAIL_DEBOUNCE);
  localparam logic signed [SAMPLE_W:0] SLOW_ROUND = (SAMPLE_W+1)'((1 << SLOW_SHIFT) - 1);
  localparam logic signed [SAMPLE_W:0] FAST_ROUND = (SAMPLE_W+1)'((1 << FAST_SHIFT) - 1);

  typedef struct packed {
    logic                       eval;
    logic                       clear;
    logic                       arm;
    logic                       fault;
    logic signed [SAMPLE_W:0]   rate;
    logic signed [SAMPLE_W-1:0] x;
  } trig_req_t;

  typedef struct packed {
    logic                     trig;
    logic                     fault;
    logic signed [SAMPLE_W:0] diff;
  } snap_t;

  typedef struct packed {
    logic                trig;
    logic                fault;
    logic                neg;
    logic [SAMPLE_W-1:0] dmag;
  } div_t;

  // configuration
  logic signed [SAMPLE_W-1:0] sensitivity;

  // front state
  logic                       enabled, enabled_next;
  logic                       seed_pending, seed_pending_next;
  logic signed [SAMPLE_W-1:0] slow_average, slow_average_next;
  logic signed [SAMPLE_W-1:0] fast_average, fast_average_next;
  logic [3:0]                 rail_count, rail_count_next;
  logic                       fault_latched, fault_latched_next;
  logic signed [SUM_W-1:0]    window_sum, window_sum_next;
  logic [PTR_W-1:0]           window_pointer, window_pointer_next;
  logic                       wrapped, wrapped_next;
  logic signed [SAMPLE_W-1:0] last_raw, last_raw_next;

  // trigger state
  logic                       trigger_level, trigger_level_next;
  logic                       homing_armed, homing_armed_next;
  logic signed [SAMPLE_W-1:0] homing_reference, homing_reference_next;
  logic signed [SAMPLE_W:0]   homing_difference, homing_difference_next;

  // pipeline
  logic                    p1_valid, p2_valid, p3_valid;
  trig_req_t               p1, p1_in;
  logic signed [SUM_W-1:0] p1_sum;
  snap_t                   p2;
  logic signed [SUM_W-1:0] p2_sum;
  div_t                    p3;
  logic [SUM_W-1:0]        p3_abs, p3_q0;

  logic load_out, load_p3, load_p2, load_p1, accept;

  // window ram
  logic                ram_we;
  logic [PTR_W-1:0]    ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  assign load_out   = !result_valid || !result_stall;
  assign load_p3    = !p3_valid || load_out;
  assign load_p2    = !p2_valid || load_p3;
  assign load_p1    = !p1_valid || load_p2;
  assign item_stall = !load_p1;
  assign accept     = item_valid && !item_stall;

  // ---------------------------------------------------------------- front stage
  logic signed [SAMPLE_W-1:0] x;
  logic [SAMPLE_W-1:0]        mag;
  logic                       railed;
  logic [3:0]                 rail_inc;
  logic                       goes_fault;
  logic signed [SAMPLE_W:0]   ds, ds_adj, qs, slow_sum;
  logic signed [SAMPLE_W:0]   df, df_adj, qf, fast_sum;
  logic signed [SAMPLE_W-1:0] slow_upd, fast_upd;
  logic signed [SAMPLE_W:0]   rate_upd;
  logic signed [SUM_W-1:0]    old_ext;

  assign x          = item.raw_sample;
  assign mag        = x[SAMPLE_W-1] ? (~x + 1'b1) : x;
  assign railed     = mag > RAIL_LIMIT;
  assign rail_inc   = (rail_count < RAIL_SAT) ? rail_count + 4'd1 : rail_count;
  assign goes_fault = railed && (rail_inc >= DEBOUNCE);

  // truncating division: bias negative differences before the arithmetic shift
  assign ds       = (SAMPLE_W+1)'(x) - (SAMPLE_W+1)'(slow_average);
  assign ds_adj   = ds + (ds[SAMPLE_W] ? SLOW_ROUND : '0);
  assign qs       = ds_adj >>> SLOW_SHIFT;
  assign slow_sum = (SAMPLE_W+1)'(slow_average) + qs;
  assign slow_upd = slow_sum[SAMPLE_W-1:0];

  assign df       = (SAMPLE_W+1)'(x) - (SAMPLE_W+1)'(fast_average);
  assign df_adj   = df + (df[SAMPLE_W] ? FAST_ROUND : '0);
  assign qf       = df_adj >>> FAST_SHIFT;
  assign fast_sum = (SAMPLE_W+1)'(fast_average) + qf;
  assign fast_upd = fast_sum[SAMPLE_W-1:0];

  assign rate_upd = (SAMPLE_W+1)'(fast_upd) - (SAMPLE_W+1)'(slow_upd);

  // entries not yet written since reset count as zero
  assign old_ext = wrapped ? SUM_W'($signed(ram_rdata)) : '0;

  always_comb begin
    enabled_next        = enabled;
    seed_pending_next   = seed_pending;
    slow_average_next   = slow_average;
    fast_average_next   = fast_average;
    rail_count_next     = rail_count;
    fault_latched_next  = fault_latched;
    window_sum_next     = window_sum;
    window_pointer_next = window_pointer;
    wrapped_next        = wrapped;
    last_raw_next       = last_raw;
    ram_we              = 1'b0;
    p1_in.eval          = 1'b0;
    p1_in.clear         = 1'b0;
    p1_in.arm           = 1'b0;
    p1_in.rate          = rate_upd;
    p1_in.x             = x;
    if (accept) begin
      case (item.kind)
        KIND_SAMPLE: begin
          if (enabled && !fault_latched) begin
            last_raw_next = x;
            if (railed) begin
              rail_count_next = rail_inc;
            end else begin
              rail_count_next = '0;
            end
            if (goes_fault) begin
              fault_latched_next = 1'b1;
            end else begin
              ram_we          = 1'b1;
              window_sum_next = window_sum - old_ext + SUM_W'(x);
              if (window_pointer == LAST_PTR) begin
                window_pointer_next = '0;
                wrapped_next        = 1'b1;
              end else begin
                window_pointer_next = window_pointer + 1'b1;
              end
              if (seed_pending) begin
                slow_average_next = x;
                fast_average_next = x;
                seed_pending_next = 1'b0;
              end else begin
                slow_average_next = slow_upd;
                fast_average_next = fast_upd;
                p1_in.eval        = 1'b1;
              end
            end
          end
        end
        KIND_ENABLE: begin
          enabled_next      = 1'b1;
          seed_pending_next = 1'b1;
          slow_average_next = '0;
          fast_average_next = '0;
          rail_count_next   = '0;
          p1_in.clear       = 1'b1;
        end
        KIND_DISABLE: begin
          enabled_next = 1'b0;
          p1_in.clear  = 1'b1;
        end
        KIND_ARM: begin
          p1_in.arm = 1'b1;
          p1_in.x   = last_raw;
        end
        default: ;
      endcase
    end
    p1_in.fault = fault_latched_next;
  end

  // read at the next pointer so the data for the current pointer is always ready
  assign ram_raddr = rst ? '0 : window_pointer_next;

  lctd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_LENGTH)
  ) u_window_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (window_pointer),
    .wdata (x),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity    <= '0;
      enabled        <= 1'b0;
      seed_pending   <= 1'b0;
      slow_average   <= '0;
      fast_average   <= '0;
      rail_count     <= '0;
      fault_latched  <= 1'b0;
      window_sum     <= '0;
      window_pointer <= '0;
      wrapped        <= 1'b0;
      last_raw       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sensitivity <= cfg_data;
      end
      enabled        <= enabled_next;
      seed_pending   <= seed_pending_next;
      slow_average   <= slow_average_next;
      fast_average   <= fast_average_next;
      rail_count     <= rail_count_next;
      fault_latched  <= fault_latched_next;
      window_sum     <= window_sum_next;
      window_pointer <= window_pointer_next;
      wrapped        <= wrapped_next;
      last_raw       <= last_raw_next;
    end
  end

  // -------------------------------------------------------------- trigger stage
  logic                     p1_move;
  logic signed [SAMPLE_W+1:0] rate_ext, sens_ext;
  logic                     rate_hit;

  assign p1_move  = p1_valid && load_p2;
  assign rate_ext = (SAMPLE_W+2)'(p1.rate);
  assign sens_ext = (SAMPLE_W+2)'(sensitivity);
  // threshold applied as written, both sides against the signed sensitivity
  assign rate_hit = (rate_ext < sens_ext) || (rate_ext > -sens_ext);

  always_comb begin
    trigger_level_next     = trigger_level;
    homing_armed_next      = homing_armed;
    homing_reference_next  = homing_reference;
    homing_difference_next = homing_difference;
    if (p1_move) begin
      if (p1.clear) begin
        trigger_level_next = 1'b0;
      end
      if (p1.arm) begin
        homing_armed_next     = 1'b1;
        homing_reference_next = p1.x;
      end
      if (p1.eval) begin
        if (rate_hit) begin
          if (!trigger_level) begin
            trigger_level_next = 1'b1;
            if (homing_armed) begin
              homing_armed_next      = 1'b0;
              homing_difference_next = (SAMPLE_W+1)'(homing_reference)
                                     - (SAMPLE_W+1)'(p1.x);
            end
          end
        end else begin
          trigger_level_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_level     <= 1'b0;
      homing_armed      <= 1'b0;
      homing_reference  <= '0;
      homing_difference <= '0;
    end else begin
      trigger_level     <= trigger_level_next;
      homing_armed      <= homing_armed_next;
      homing_reference  <= homing_reference_next;
      homing_difference <= homing_difference_next;
    end
  end

  // ------------------------------------------------------------- divide stages
  logic [SUM_W-1:0]    sum_abs;
  logic [2*SUM_W-1:0]  recip_prod;
  logic [SAMPLE_W:0]   diff_abs;
  logic [2*SUM_W-1:0]  back_prod;
  logic [SUM_W-1:0]    rem, quot, avg_full;

  assign sum_abs    = p2_sum[SUM_W-1] ? SUM_W'(-p2_sum) : SUM_W'(p2_sum);
  assign recip_prod = sum_abs * RECIP;
  assign diff_abs   = p2.diff[SAMPLE_W] ? (SAMPLE_W+1)'(-p2.diff) : (SAMPLE_W+1)'(p2.diff);

  // reciprocal estimate is low by at most one
  assign back_prod = p3_q0 * LEN_W;
  assign rem       = p3_abs - back_prod[SUM_W-1:0];
  assign quot      = (rem >= LEN_W) ? p3_q0 + 1'b1 : p3_q0;
  assign avg_full  = p3.neg ? -quot : quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid     <= 1'b0;
      p2_valid     <= 1'b0;
      p3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (load_p1) begin
        p1_valid <= accept;
      end
      if (load_p2) begin
        p2_valid <= p1_valid;
      end
      if (load_p3) begin
        p3_valid <= p2_valid;
      end
      if (load_out) begin
        result_valid <= p3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_p1 && accept) begin
      p1     <= p1_in;
      p1_sum <= window_sum_next;
    end
    if (p1_move) begin
      p2.trig  <= trigger_level_next;
      p2.fault <= p1.fault;
      p2.diff  <= homing_difference_next;
      p2_sum   <= p1_sum;
    end
    if (load_p3 && p2_valid) begin
      p3.trig  <= p2.trig;
      p3.fault <= p2.fault;
      p3.neg   <= p2_sum[SUM_W-1];
      p3.dmag  <= diff_abs[SAMPLE_W-1:0];
      p3_abs   <= sum_abs;
      p3_q0    <= recip_prod[2*SUM_W-1:SUM_W];
    end
    if (load_out && p3_valid) begin
      result.trigger_out    <= p3.trig;
      result.moving_average <= avg_full[SAMPLE_W-1:0];
      result.diff_magnitude <= p3.dmag;
      result.fault          <= p3.fault;
    end
  end

  // ----------------------------------------------------------------- checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("request stalled while the output side could move");

  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    fault_latched |=> fault_latched)
    else $error("latched fault cleared without reset");

  a_pointer_range: assert property (@(posedge clk) disable iff (rst)
    window_pointer <= LAST_PTR)
    else $error("window pointer beyond the last entry");

  a_rail_count_bound: assert property (@(posedge clk) disable iff (rst)
    rail_count <= DEBOUNCE)
    else $error("rail count ran past the debounce limit");

endmodule

`default_nettype wire

### bench/tb_load_cell_tap_detector_core.sv
// self-checking bench for load_cell_tap_detector_core: directed table, then random
// episodes under several sensitivity settings, checked against a behavioural tap model
// depends on rtl/lctd_pkg.sv, rtl/lctd_ram.sv and rtl/load_cell_tap_detector_core.sv
module tb_load_cell_tap_detector_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lctd_pkg::*;

  localparam int WINDOW     = 50;
  localparam int DEBOUNCE   = 10;
  localparam int PHASE_REQS = 170;
  localparam int STOP_AFTER = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic signed [23:0] cfg_data = '0;

  always #10 clk = ~clk;

  load_cell_tap_detector_core #(
    .WINDOW_LENGTH(WINDOW),
    .RAIL_DEBOUNCE(DEBOUNCE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // tap model state; the samples, averages and counters are kept at the block's widths
  logic               en_q, seed_q, trig_q, fault_q, armed_q;
  logic signed [23:0] slow_q, fast_q, last_q, ref_q, sens_q;
  logic signed [24:0] diff_q;
  logic [3:0]         rails_q;
  logic signed [23:0] win_store [WINDOW];
  logic signed [30:0] win_sum;
  int                 win_ptr;

  result_t tap_reports_due [$];
  item_t   stim_q [$];
  item_t   table_items [$];
  bit      table_typed [$];
  result_t table_res [$];

  int  cycle_count = 0;
  int  reports_seen = 0;
  int  bad_reports = 0;
  int  requests_sent = 0;
  int  trigger_rises = 0;
  int  captures = 0;
  int  settings_used = 0;
  int  tx_odds = 6;
  int  rx_odds = 6;
  int  stall_left = 0;
  bit  gen_en;
  int  gen_rails;
  int  live_items;

  function automatic bit is_railed(input int x);
    return ((x < 0) ? -x : x) > int'(RAIL_LIMIT);
  endfunction

  function automatic int clamp24(input int v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic int rand24();
    return int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
  endfunction

  task automatic take_reading(input int x);
    int rate;
    int s;
    last_q = x[23:0];
    if (is_railed(x)) begin
      if (rails_q != RAIL_SAT) rails_q = rails_q + 4'd1;
      if (rails_q >= DEBOUNCE) begin
        fault_q = 1'b1;
        return;
      end
    end else begin
      rails_q = '0;
    end
    win_sum = win_sum - win_store[win_ptr] + x;
    win_store[win_ptr] = x[23:0];
    win_ptr = (win_ptr == WINDOW - 1) ? 0 : win_ptr + 1;
    if (seed_q) begin
      slow_q = x[23:0];
      fast_q = x[23:0];
      seed_q = 1'b0;
      return;
    end
    slow_q = int'(slow_q) + (x - int'(slow_q)) / 128;
    fast_q = int'(fast_q) + (x - int'(fast_q)) / 32;
    rate = int'(fast_q) - int'(slow_q);
    s = int'(sens_q);
    // threshold applied exactly as written, sign of sensitivity and all
    if (rate < s || rate > -s) begin
      if (!trig_q) begin
        trig_q = 1'b1;
        trigger_rises++;
        if (armed_q) begin
          armed_q = 1'b0;
          diff_q = int'(ref_q) - x;
          captures++;
        end
      end
    end else begin
      trig_q = 1'b0;
    end
  endtask

  task automatic run_tap_model(input item_t it, output result_t r);
    longint avg;
    int d;
    case (it.kind)
      KIND_SAMPLE: begin
        if (en_q && !fault_q) take_reading(int'(it.raw_sample));
      end
      KIND_ENABLE: begin
        en_q = 1'b1;
        seed_q = 1'b1;
        slow_q = '0;
        fast_q = '0;
        trig_q = 1'b0;
        rails_q = '0;
      end
      KIND_DISABLE: begin
        en_q = 1'b0;
        trig_q = 1'b0;
      end
      default: begin
        armed_q = 1'b1;
        ref_q = last_q;
      end
    endcase
    avg = longint'(win_sum) / longint'(WINDOW);
    d = int'(diff_q);
    if (d < 0) d = -d;
    r.trigger_out = trig_q;
    r.moving_average = avg[23:0];
    r.diff_magnitude = d[23:0];
    r.fault = fault_q;
  endtask

  // one request; the model runs at the edge that accepts it
  task automatic push_item(input item_t it, input bit typed, input result_t typed_res);
    result_t r;
    if (tx_odds != 0 && $urandom_range(0, tx_odds - 1) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    run_tap_model(it, r);
    tap_reports_due.push_back(typed ? typed_res : r);
    requests_sent++;
  endtask

  task automatic write_sensitivity(input int v);
    while (tap_reports_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v[23:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sens_q = v[23:0];
    settings_used++;
  endtask

  task automatic add_row(input kind_e k, input int x, input bit typed = 1'b0,
                         input result_t r = '0);
    item_t it;
    it.kind = k;
    it.raw_sample = x[23:0];
    table_items.push_back(it);
    table_typed.push_back(typed);
    table_res.push_back(r);
  endtask

  task automatic add_stim(input kind_e k, input int x);
    item_t it;
    it.kind = k;
    it.raw_sample = x[23:0];
    if (k == KIND_ENABLE) begin
      gen_en = 1'b1;
      gen_rails = 0;
    end
    if (k == KIND_DISABLE) gen_en = 1'b0;
    if (k == KIND_SAMPLE) begin
      // counted even while disabled, so the guard errs on the safe side
      gen_rails = is_railed(x) ? gen_rails + 1 : 0;
      if (gen_en) live_items++;
    end else begin
      live_items++;
    end
    stim_q.push_back(it);
  endtask

  // keeps a railed run short of the debounce count unless a fault is wanted
  function automatic int guard(input int x, input bit fault_ok);
    if (!fault_ok && is_railed(x) && gen_rails >= DEBOUNCE - 2) return x / 2;
    return x;
  endfunction

  function automatic int railed_value();
    int x;
    x = 8372225 + int'($urandom_range(0, 16382));
    if ($urandom_range(0, 1) == 1) x = -x - int'($urandom_range(0, 1));
    return x;
  endfunction

  task automatic add_episode();
    int base;
    int pick;
    add_stim(KIND_ENABLE, $urandom);
    base = int'($urandom_range(0, 14680064)) - 7340032;
    repeat ($urandom_range(20, 120)) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        add_stim(KIND_ARM, $urandom);
      end else if (pick < 7) begin
        add_stim(KIND_SAMPLE, guard(railed_value(), 1'b0));
      end else if (pick < 10) begin
        add_stim(KIND_SAMPLE, guard(rand24(), 1'b0));
      end else if (pick < 12) begin
        add_stim(KIND_DISABLE, $urandom);
        repeat ($urandom_range(0, 2)) add_stim(KIND_SAMPLE, rand24());
        add_stim(KIND_ENABLE, $urandom);
      end else if (pick < 14) begin
        add_stim(kind_e'($urandom_range(0, 3)), guard(rand24(), 1'b0));
      end else if (pick < 26) begin
        // a tap: a step in the baseline
        base = base + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(300, 400000));
        if (base > 8000000) base = 8000000;
        if (base < -8000000) base = -8000000;
        add_stim(KIND_SAMPLE, guard(clamp24(base + int'($urandom_range(0, 128)) - 64), 1'b0));
      end else begin
        add_stim(KIND_SAMPLE, guard(clamp24(base + int'($urandom_range(0, 128)) - 64), 1'b0));
      end
    end
    if ($urandom_range(0, 1) == 1) add_stim(KIND_DISABLE, $urandom);
  endtask

  task automatic run_phase(input int sens, input bit last);
    int pick_odds [3];
    pick_odds = '{0, 4, 12};
    write_sensitivity(sens);
    tx_odds = last ? 0 : pick_odds[$urandom_range(0, 2)];
    rx_odds = last ? 0 : pick_odds[$urandom_range(0, 2)];
    stim_q.delete();
    live_items = 0;
    while (live_items < PHASE_REQS) add_episode();
    if (last) begin
      // ten railed samples in a row latch the fault; after it samples are ignored
      add_stim(KIND_ENABLE, $urandom);
      repeat (DEBOUNCE) add_stim(KIND_SAMPLE, railed_value());
      repeat (25) add_stim(kind_e'($urandom_range(0, 3)), rand24());
    end
    while (stim_q.size() != 0) push_item(stim_q.pop_front(), 1'b0, '0);
    item_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > STOP_AFTER) begin
      $display("timed out after %0d cycles, %0d reports outstanding", cycle_count,
               tap_reports_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      reports_seen++;
      if (tap_reports_due.size() == 0) begin
        bad_reports++;
        if (bad_reports <= 10)
          $display("%0t: report with no request behind it: trig=%0b avg=%0d diff=%0d fault=%0b",
                   $realtime, result.trigger_out, result.moving_average,
                   result.diff_magnitude, result.fault);
      end else begin
        want = tap_reports_due.pop_front();
        if (result.trigger_out !== want.trigger_out ||
            result.moving_average !== want.moving_average ||
            result.diff_magnitude !== want.diff_magnitude ||
            result.fault !== want.fault) begin
          bad_reports++;
          if (bad_reports <= 10)
            $display("%0t: report %0d mismatch: trig %0b/%0b avg %0d/%0d diff %0d/%0d fault %0b/%0b",
                     $realtime, reports_seen, want.trigger_out, result.trigger_out,
                     want.moving_average, result.moving_average,
                     want.diff_magnitude, result.diff_magnitude, want.fault, result.fault);
        end
      end
    end
    // receiver back-pressure in bursts
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else if (rx_odds != 0 && $urandom_range(0, rx_odds - 1) == 0) begin
      stall_left <= $urandom_range(0, 18);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  initial begin
    int sens_plan [7];
    en_q = 1'b0;
    seed_q = 1'b0;
    trig_q = 1'b0;
    fault_q = 1'b0;
    armed_q = 1'b0;
    slow_q = '0;
    fast_q = '0;
    last_q = '0;
    ref_q = '0;
    sens_q = '0;
    diff_q = '0;
    rails_q = '0;
    win_sum = '0;
    win_ptr = 0;
    foreach (win_store[i]) win_store[i] = '0;
    gen_en = 1'b0;
    gen_rails = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    write_sensitivity(0);

    add_row(KIND_ARM, 0, 1'b1, '0);
    add_row(KIND_SAMPLE, 123, 1'b1, '0);
    add_row(KIND_DISABLE, -5, 1'b1, '0);
    add_row(KIND_ENABLE, 0, 1'b1, '0);
    add_row(KIND_SAMPLE, 8388607, 1'b1, '{1'b0, 24'sd167772, 24'd0, 1'b0});
    add_row(KIND_SAMPLE, -8388608);
    add_row(KIND_SAMPLE, 8372224);
    add_row(KIND_SAMPLE, -8372224);
    add_row(KIND_SAMPLE, 8372225);
    add_row(KIND_ARM, 0);
    add_row(KIND_ENABLE, 0);
    add_row(KIND_SAMPLE, 100);
    add_row(KIND_SAMPLE, 100);
    add_row(KIND_SAMPLE, 5000);
    add_row(KIND_SAMPLE, -8372225);
    add_row(KIND_ARM, 0);
    add_row(KIND_ENABLE, 0);
    add_row(KIND_SAMPLE, -1);
    add_row(KIND_SAMPLE, -8388608);
    add_row(KIND_DISABLE, 0);
    add_row(KIND_SAMPLE, 777);
    add_row(KIND_ARM, 0);
    add_row(KIND_SAMPLE, 0);
    foreach (table_items[i]) push_item(table_items[i], table_typed[i], table_res[i]);
    item_valid <= 1'b0;

    sens_plan[0] = 8388607;
    sens_plan[1] = -8388608;
    sens_plan[2] = -int'($urandom_range(100, 3000));
    sens_plan[3] = int'($urandom_range(0, 500));
    sens_plan[4] = rand24();
    sens_plan[5] = -int'($urandom_range(3000, 20000));
    sens_plan[6] = -int'($urandom_range(50, 2000));
    foreach (sens_plan[i]) run_phase(sens_plan[i], i == 6);

    while (tap_reports_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("%0d requests over %0d sensitivity settings, %0d reports checked",
             requests_sent, settings_used, reports_seen);
    $display("%0d trigger rises, %0d homing captures, fault latched %0b, %0d mismatches",
             trigger_rises, captures, fault_q, bad_reports);
    if (bad_reports == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
